/* rtl/tst_pkg.sv */
package tst_pkg;

  localparam int SLOTS_DEF      = 32;
  localparam int ID_BITS_DEF    = 32;
  localparam int OWNER_BITS_DEF = 32;

  typedef logic [31:0] word_t;
  typedef logic [5:0]  cnt_t;

  typedef enum logic [2:0] {
    KIND_ALLOC  = 3'd0,
    KIND_FREE   = 3'd1,
    KIND_DETACH = 3'd2,
    KIND_COUNT  = 3'd3,
    KIND_LOOKUP = 3'd4,
    KIND_LIST   = 3'd5,
    KIND_CLEAR  = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    ST_UNUSED   = 2'd0,
    ST_ACTIVE   = 2'd1,
    ST_DETACHED = 2'd2
  } slot_st_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_ERR  = 2'd1,
    STAT_FULL = 2'd2
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic start;      // capture the request word, rewind the scan
    logic scan;       // advance the slot scan
    logic restart;    // resume the scan after the held entry
    logic load_hit;   // load the result for the entry found
    logic load_done;  // load the closing result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic skip;       // operation answers without a scan
    logic stop_hit;   // scan found the entry it stops on
    logic ev_end;     // last slot has been looked at
    logic out_free;   // output register can take a word
    logic more;       // list has further entries to send
  } sts_t;

endpackage

/* rtl/tst_if.sv */
interface tst_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] thread_id;
  logic [31:0] owner_id;
  logic        owner_alive;
  logic [5:0]  list_room;

  modport source (
    output valid, kind, thread_id, owner_id, owner_alive, list_room,
    input  ready
  );
  modport sink (
    input  valid, kind, thread_id, owner_id, owner_alive, list_room,
    output ready
  );
endinterface

interface tst_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] id_out;
  logic [31:0] owner_out;
  logic [1:0]  state_out;
  logic [5:0]  match_count;
  logic [5:0]  live_count;
  logic        last;

  modport source (
    output valid, status, id_out, owner_out, state_out, match_count, live_count, last,
    input  ready
  );
  modport sink (
    input  valid, status, id_out, owner_out, state_out, match_count, live_count, last,
    output ready
  );
endinterface

/* rtl/thread_slot_table_core.sv */
// Thread slot table: SLOTS slots of (id, owner, state), one operation per input
// word selected by kind. Every operation except clear, a bad kind, an allocate
// for a dead owner and a list that is empty or short of room scans the slots one
// per cycle through a registered read of the id/owner store. A single-result
// operation ends its scan at the last slot or on the slot it stops on; the short
// cases answer without a scan. A list sends one word per used slot in slot order
// and resumes its scan after each word but the last is loaded. Stalls on the
// output hold back the result load. The slot scan sets the rate: one slot is
// looked at per cycle.
// A new request can be taken as soon as the previous result is in the output
// register, even while that word still waits for ready.
module thread_slot_table_core #(
  parameter int SLOTS      = tst_pkg::SLOTS_DEF,
  parameter int ID_BITS    = tst_pkg::ID_BITS_DEF,
  parameter int OWNER_BITS = tst_pkg::OWNER_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tst_in_if.sink    in_i,
  tst_out_if.source out_o
);

  tst_pkg::cmd_t cmd;
  tst_pkg::sts_t sts;
  logic          in_ready;

  tst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tst_datapath #(
    .SLOTS      (SLOTS),
    .ID_BITS    (ID_BITS),
    .OWNER_BITS (OWNER_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .kind_i        (in_i.kind),
    .thread_id_i   (in_i.thread_id),
    .owner_id_i    (in_i.owner_id),
    .owner_alive_i (in_i.owner_alive),
    .list_room_i   (in_i.list_room),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .status_o      (out_o.status),
    .id_out_o      (out_o.id_out),
    .owner_out_o   (out_o.owner_out),
    .state_out_o   (out_o.state_out),
    .match_count_o (out_o.match_count),
    .live_count_o  (out_o.live_count),
    .last_o        (out_o.last)
  );

  assign in_i.ready = in_ready;

endmodule

/* rtl/tst_ctrl.sv */
module tst_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  tst_pkg::sts_t sts_i,
  output tst_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_HIT  = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.skip) begin
          state_d = S_DONE;
        end else begin
          cmd_o.scan = 1'b1;
          if (sts_i.stop_hit) begin
            state_d = S_HIT;
          end else if (sts_i.ev_end) begin
            state_d = S_DONE;
          end
        end
      end
      S_HIT: begin
        if (sts_i.out_free) begin
          cmd_o.load_hit = 1'b1;
          if (sts_i.more) begin
            cmd_o.restart = 1'b1;
            state_d       = S_SCAN;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_done = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/tst_datapath.sv */
module tst_datapath #(
  parameter int SLOTS      = tst_pkg::SLOTS_DEF,
  parameter int ID_BITS    = tst_pkg::ID_BITS_DEF,
  parameter int OWNER_BITS = tst_pkg::OWNER_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tst_pkg::cmd_t  cmd_i,
  output tst_pkg::sts_t  sts_o,
  input  logic [2:0]     kind_i,
  input  tst_pkg::word_t thread_id_i,
  input  tst_pkg::word_t owner_id_i,
  input  logic           owner_alive_i,
  input  tst_pkg::cnt_t  list_room_i,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  output logic [1:0]     status_o,
  output tst_pkg::word_t id_out_o,
  output tst_pkg::word_t owner_out_o,
  output logic [1:0]     state_out_o,
  output tst_pkg::cnt_t  match_count_o,
  output tst_pkg::cnt_t  live_count_o,
  output logic           last_o
);

  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LIVE_W = $clog2(SLOTS + 1);
  localparam int CMP_W  = (LIVE_W > 6) ? LIVE_W : 6;

  // request word
  logic [2:0]            op_kind_q;
  logic [ID_BITS-1:0]    op_tid_q;
  logic [OWNER_BITS-1:0] op_own_q;
  logic                  op_alive_q;
  tst_pkg::cnt_t         op_room_q;

  // slot table
  logic [ID_BITS-1:0]    mem_id  [SLOTS];
  logic [OWNER_BITS-1:0] mem_own [SLOTS];
  tst_pkg::slot_st_e     st_q    [SLOTS];
  logic [LIVE_W-1:0]     live_q;
  logic [ID_BITS-1:0]    nid_q;

  // scan: read stage and look stage
  logic [IDX_W-1:0]      rd_idx_q;
  logic                  rd_done_q;
  logic                  ev_valid_q;
  logic [IDX_W-1:0]      ev_idx_q;
  tst_pkg::slot_st_e     ev_st_q;
  logic [ID_BITS-1:0]    ev_id_q;
  logic [OWNER_BITS-1:0] ev_own_q;
  logic [LIVE_W-1:0]     n_q;
  logic [LIVE_W-1:0]     k_q;

  // output register
  logic                  out_valid_q;
  tst_pkg::status_e      out_status_q;
  tst_pkg::word_t        out_id_q;
  tst_pkg::word_t        out_own_q;
  tst_pkg::slot_st_e     out_st_q;
  tst_pkg::cnt_t         out_match_q;
  tst_pkg::cnt_t         out_live_q;
  logic                  out_last_q;

  logic [ID_BITS-1:0]    tid_in;
  logic [OWNER_BITS-1:0] own_in;
  logic [ID_BITS-1:0]    alloc_id;
  logic                  rd_en;
  logic                  id_match;
  logic                  own_match;
  logic                  hit;
  logic                  stop_kind;
  logic                  count_kind;
  logic                  list_last;
  logic                  room_short;
  logic                  skip;
  logic                  load;

  tst_pkg::status_e      res_status;
  logic [ID_BITS-1:0]    res_id;
  logic [OWNER_BITS-1:0] res_own;
  tst_pkg::slot_st_e     res_st;
  tst_pkg::cnt_t         res_match;
  logic [LIVE_W-1:0]     res_live;
  logic                  res_last;

  assign tid_in   = ID_BITS'(thread_id_i);
  assign own_in   = OWNER_BITS'(owner_id_i);
  // id 0 is skipped when the counter wraps
  assign alloc_id = (nid_q == '0) ? ID_BITS'(1) : nid_q;

  assign id_match  = (ev_st_q != tst_pkg::ST_UNUSED) && (ev_id_q == op_tid_q) &&
                     (op_tid_q != '0);
  assign own_match = (ev_st_q == tst_pkg::ST_ACTIVE) && (ev_own_q == op_own_q);

  assign list_last  = ((LIVE_W + 1)'(k_q) + (LIVE_W + 1)'(1)) == (LIVE_W + 1)'(live_q);
  assign room_short = CMP_W'(op_room_q) < CMP_W'(live_q);
  assign load       = cmd_i.load_hit || cmd_i.load_done;

  always_comb begin
    hit        = 1'b0;
    stop_kind  = 1'b0;
    count_kind = 1'b0;
    skip       = 1'b0;
    case (op_kind_q)
      tst_pkg::KIND_ALLOC: begin
        hit       = (ev_st_q == tst_pkg::ST_UNUSED);
        stop_kind = 1'b1;
        skip      = !op_alive_q;
      end
      tst_pkg::KIND_FREE, tst_pkg::KIND_LOOKUP: begin
        hit       = id_match;
        stop_kind = 1'b1;
      end
      tst_pkg::KIND_DETACH, tst_pkg::KIND_COUNT: begin
        count_kind = 1'b1;
      end
      tst_pkg::KIND_LIST: begin
        hit       = (ev_st_q != tst_pkg::ST_UNUSED);
        stop_kind = 1'b1;
        skip      = room_short || (live_q == '0);
      end
      tst_pkg::KIND_CLEAR: begin
        skip = 1'b1;
      end
      default: begin
        skip = 1'b1;
      end
    endcase
  end

  assign sts_o.skip     = skip;
  assign sts_o.stop_hit = ev_valid_q && stop_kind && hit;
  assign sts_o.ev_end   = ev_valid_q && (ev_idx_q == IDX_W'(SLOTS - 1));
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign sts_o.more     = (op_kind_q == tst_pkg::KIND_LIST) && !list_last;

  // no new read once the entry to stop on sits in the look stage
  assign rd_en = cmd_i.scan && !rd_done_q && !sts_o.stop_hit;

  always_comb begin
    res_status = tst_pkg::STAT_OK;
    res_id     = '0;
    res_own    = '0;
    res_st     = tst_pkg::ST_UNUSED;
    res_match  = '0;
    res_live   = live_q;
    res_last   = 1'b1;
    if (cmd_i.load_hit) begin
      case (op_kind_q)
        tst_pkg::KIND_ALLOC: begin
          res_id   = alloc_id;
          res_own  = op_own_q;
          res_st   = tst_pkg::ST_ACTIVE;
          res_live = live_q + LIVE_W'(1);
        end
        tst_pkg::KIND_FREE: begin
          res_id   = ev_id_q;
          res_own  = ev_own_q;
          res_live = live_q - LIVE_W'(1);
        end
        tst_pkg::KIND_LOOKUP: begin
          res_id  = ev_id_q;
          res_own = ev_own_q;
          res_st  = ev_st_q;
        end
        tst_pkg::KIND_LIST: begin
          res_id    = ev_id_q;
          res_own   = ev_own_q;
          res_st    = ev_st_q;
          res_match = tst_pkg::cnt_t'(live_q);
          res_last  = list_last;
        end
        default: begin
          res_status = tst_pkg::STAT_ERR;
        end
      endcase
    end else begin
      case (op_kind_q)
        tst_pkg::KIND_ALLOC: begin
          res_status = op_alive_q ? tst_pkg::STAT_FULL : tst_pkg::STAT_ERR;
        end
        tst_pkg::KIND_FREE, tst_pkg::KIND_LOOKUP: begin
          res_status = tst_pkg::STAT_ERR;
        end
        tst_pkg::KIND_DETACH, tst_pkg::KIND_COUNT: begin
          res_match = tst_pkg::cnt_t'(n_q);
        end
        tst_pkg::KIND_LIST: begin
          if (room_short) begin
            res_status = tst_pkg::STAT_ERR;
            res_match  = tst_pkg::cnt_t'(live_q);
          end
        end
        tst_pkg::KIND_CLEAR: begin
          res_live = '0;
        end
        default: begin
          res_status = tst_pkg::STAT_ERR;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_kind_q   <= tst_pkg::KIND_CLEAR;
      op_alive_q  <= 1'b0;
      live_q      <= '0;
      nid_q       <= ID_BITS'(1);
      rd_idx_q    <= '0;
      rd_done_q   <= 1'b0;
      ev_valid_q  <= 1'b0;
      n_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        st_q[i] <= tst_pkg::ST_UNUSED;
      end
    end else begin
      if (cmd_i.start) begin
        op_kind_q  <= kind_i;
        op_alive_q <= owner_alive_i || (own_in == '0);
        n_q        <= '0;
        k_q        <= '0;
      end

      if (cmd_i.start || cmd_i.restart) begin
        rd_idx_q   <= cmd_i.start ? '0 : ev_idx_q + IDX_W'(1);
        rd_done_q  <= cmd_i.start ? 1'b0 : (ev_idx_q == IDX_W'(SLOTS - 1));
        ev_valid_q <= 1'b0;
      end else if (cmd_i.scan) begin
        ev_valid_q <= rd_en;
        if (rd_en) begin
          if (rd_idx_q == IDX_W'(SLOTS - 1)) begin
            rd_done_q <= 1'b1;
          end else begin
            rd_idx_q <= rd_idx_q + IDX_W'(1);
          end
        end
      end

      if (cmd_i.scan && ev_valid_q && count_kind && own_match) begin
        n_q <= n_q + LIVE_W'(1);
        if (op_kind_q == tst_pkg::KIND_DETACH) begin
          st_q[ev_idx_q] <= tst_pkg::ST_DETACHED;
        end
      end

      if (cmd_i.load_hit) begin
        case (op_kind_q)
          tst_pkg::KIND_ALLOC: begin
            st_q[ev_idx_q] <= tst_pkg::ST_ACTIVE;
            nid_q          <= alloc_id + ID_BITS'(1);
          end
          tst_pkg::KIND_FREE: begin
            st_q[ev_idx_q] <= tst_pkg::ST_UNUSED;
          end
          tst_pkg::KIND_LIST: begin
            k_q <= k_q + LIVE_W'(1);
          end
          default: begin
          end
        endcase
      end

      if (cmd_i.load_done && (op_kind_q == tst_pkg::KIND_CLEAR)) begin
        nid_q <= ID_BITS'(1);
        for (int i = 0; i < SLOTS; i++) begin
          st_q[i] <= tst_pkg::ST_UNUSED;
        end
      end

      if (load) begin
        live_q      <= res_live;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_tid_q  <= tid_in;
      op_own_q  <= own_in;
      op_room_q <= list_room_i;
    end
    if (rd_en) begin
      ev_idx_q <= rd_idx_q;
      ev_st_q  <= st_q[rd_idx_q];
    end
    if (load) begin
      out_status_q <= res_status;
      out_id_q     <= tst_pkg::word_t'(res_id);
      out_own_q    <= tst_pkg::word_t'(res_own);
      out_st_q     <= res_st;
      out_match_q  <= res_match;
      out_live_q   <= tst_pkg::cnt_t'(res_live);
      out_last_q   <= res_last;
    end
  end

  // id and owner store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_hit && (op_kind_q == tst_pkg::KIND_ALLOC)) begin
      mem_id[ev_idx_q]  <= alloc_id;
      mem_own[ev_idx_q] <= op_own_q;
    end
    if (rd_en) begin
      ev_id_q  <= mem_id[rd_idx_q];
      ev_own_q <= mem_own[rd_idx_q];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign id_out_o      = out_id_q;
  assign owner_out_o   = out_own_q;
  assign state_out_o   = out_st_q;
  assign match_count_o = out_match_q;
  assign live_count_o  = out_live_q;
  assign last_o        = out_last_q;

  a_live_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q <= LIVE_W'(SLOTS))
    else $error("live count above slot count");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a pending word");

  a_list_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_hit && (op_kind_q == tst_pkg::KIND_LIST)) |-> (k_q < live_q))
    else $error("list sends more entries than are used");

  a_alloc_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_hit && (op_kind_q == tst_pkg::KIND_ALLOC)) |=>
      (live_q == $past(live_q) + LIVE_W'(1)))
    else $error("allocate did not add a used slot");

endmodule
